// File: rtl/core/wik_pkg.sv
// Shared types, widths and constants of the wheel inverse kinematics core.
// Used by wik_regs, wik_lane and wheel_inverse_kinematics_core; depends on nothing.
package wik_pkg;

  localparam int NUM_WHEELS = 4;

  localparam int VEL_W    = 16;
  localparam int RPM_W    = 13;
  localparam int RPM_MW   = 12;
  localparam int PWM_W    = 9;
  localparam int PULSE_W  = 18;

  localparam int PWM_FULL_SCALE = 255;
  localparam int PWM_LIMIT      = 255;
  localparam int PWM_QW         = $clog2(PWM_FULL_SCALE + 1);
  localparam int DIVD_W         = RPM_MW + PWM_QW;
  localparam int DIV_H1         = PWM_QW / 2;

  localparam int MODE_W    = 2;
  localparam int K_W       = 16;
  localparam int DIST_W    = 12;
  localparam int CPR_W     = 12;
  localparam int PER_W     = 8;
  localparam int RADIUS_W  = DIST_W + 1;
  localparam int PSCALE_W  = CPR_W + PER_W;

  localparam logic [MODE_W-1:0] MODE_SKID    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MECANUM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OMNI    = 2'd2;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_BASE_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RPM      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RPM_PER_MPS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LR_DISTANCE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FR_DISTANCE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COUNTS_REV   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TICK_MS      = 3'd6;

  localparam logic [MODE_W-1:0] RST_BASE_MODE    = MODE_SKID;
  localparam logic [RPM_MW-1:0] RST_MAX_RPM      = 12'd330;
  localparam logic [K_W-1:0]    RST_RPM_PER_MPS  = 16'd12224;
  localparam logic [DIST_W-1:0] RST_LR_DISTANCE  = 12'd200;
  localparam logic [DIST_W-1:0] RST_FR_DISTANCE  = 12'd200;
  localparam logic [CPR_W-1:0]  RST_COUNTS_REV   = 12'd1320;
  localparam logic [PER_W-1:0]  RST_TICK_MS      = 8'd10;

  // Wheel sums share the denominator 2^22 * 2000.
  localparam int SUM_W       = 41;
  localparam int MAG_W       = 40;
  localparam int PP_HALF     = 20;
  localparam int SCALE_SHIFT = 32;

  localparam int PIPE_DEPTH  = 11;
  localparam int LANE_STAGES = 8;

  typedef struct packed {
    logic                omni;
    logic [RPM_MW-1:0]   max_rpm;
    logic [K_W-1:0]      rpm_per_mps;
    logic [RADIUS_W-1:0] radius;
    logic [PSCALE_W-1:0] pulse_scale;
  } wik_cfg_t;

endpackage

// File: rtl/core/wheel_inverse_kinematics_core.sv
// Top level of the wheel inverse kinematics core: handshake, valid chain and wheel mixing.
// Instantiates wik_regs and four wik_lane units; depends on wik_pkg.
//
// A velocity command (vel_x, vel_y, yaw_rate, signed Q4.12) enters on the s_ stream and
// one result per command leaves on the m_ stream: four clamped wheel speeds in rpm, four
// PWM duties and four encoder pulse counts per timer period. The APB-style port holds the
// drive geometry and scaling registers; write them only while no command is in flight.
// The datapath is eleven register stages long. A command passes through all eleven before its
// result is on m_tdata with m_tvalid high; while m_tready stays high a new command can be taken
// at every edge, so the sustained rate is one command per cycle. The depth is set by the
// 40-by-16 bit speed scaling, split into two partial products, the reciprocal multiplies
// that stand in for the divisions by 2000 and 60000, and the PWM divider, which resolves
// four quotient bits in each of two stages.
// Each stage carries its own valid bit and loads whenever it is empty or the stage after it can move, so
// a stalled receiver freezes only the occupied end of the pipeline and empty stages still
// fill. Outside reset, s_tready falls only when all eleven stages hold items and m_tready is low.
// Reset returns every configuration register to its default, empties the pipeline and holds s_tready low.
module wheel_inverse_kinematics_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,   // vel_x, vel_y, yaw_rate
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [159:0]               m_tdata,   // rpm_wheel1..4, pwm_wheel1..4, pulses_wheel1..4
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wik_pkg::ADDR_W-1:0] paddr,
  input  logic [wik_pkg::DATA_W-1:0] pwdata,
  output logic [wik_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import wik_pkg::*;

  localparam int T_W        = VEL_W + RADIUS_W + 1;
  localparam int PWM_BASE   = NUM_WHEELS * RPM_W;
  localparam int PULSE_BASE = PWM_BASE + NUM_WHEELS * PWM_W;
  localparam int OMNI_SHIFT = 10;
  localparam logic signed [SUM_W-1:0] C_2000   = 41'sd2000;
  localparam logic signed [SUM_W-1:0] C_OMNI_X = 41'sd1773625;
  localparam logic signed [SUM_W-1:0] C_OMNI_Y = 41'sd1024000;

  wik_cfg_t                  cfg;
  logic [PIPE_DEPTH-1:0]     vld;
  logic [PIPE_DEPTH-1:0]     load;
  logic                      in_acc;
  logic                      out_acc;
  logic signed [VEL_W-1:0]   vx1, vy1, wz1, vx2, vy2;
  logic                      omni1, omni2;
  logic signed [T_W-1:0]     t2;
  logic signed [SUM_W-1:0]   vx_e, vy_e, t_e;
  logic signed [SUM_W-1:0]   w_sum [NUM_WHEELS];
  logic signed [SUM_W-1:0]   s3    [NUM_WHEELS];
  logic signed [RPM_W-1:0]   rpm_w   [NUM_WHEELS];
  logic signed [PWM_W-1:0]   pwm_w   [NUM_WHEELS];
  logic signed [PULSE_W-1:0] pulse_w [NUM_WHEELS];

  wik_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    load[PIPE_DEPTH-1] = ~vld[PIPE_DEPTH-1] | m_tready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      load[i] = ~vld[i] | load[i+1];
    end
  end

  assign s_tready = load[0] & ~rst;
  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign in_acc   = s_tvalid & s_tready;
  assign out_acc  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      vx1   <= s_tdata[VEL_W-1:0];
      vy1   <= s_tdata[2*VEL_W-1:VEL_W];
      wz1   <= s_tdata[3*VEL_W-1:2*VEL_W];
      omni1 <= cfg.omni;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      vx2   <= vx1;
      vy2   <= vy1;
      omni2 <= omni1;
      t2    <= wz1 * $signed({1'b0, cfg.radius});
    end
  end

  assign vx_e = SUM_W'(vx2);
  assign vy_e = SUM_W'(vy2);
  assign t_e  = SUM_W'(t2);

  always_comb begin
    if (omni2) begin
      w_sum[0] = (vy_e * C_2000 + t_e) <<< OMNI_SHIFT;
      w_sum[1] = -(vx_e * C_OMNI_X) - vy_e * C_OMNI_Y + (t_e <<< OMNI_SHIFT);
      w_sum[2] = vx_e * C_OMNI_X - vy_e * C_OMNI_Y + (t_e <<< OMNI_SHIFT);
      w_sum[3] = '0;
    end else begin
      w_sum[0] = ((vx_e - vy_e) * C_2000 - t_e) <<< OMNI_SHIFT;
      w_sum[1] = ((vx_e + vy_e) * C_2000 + t_e) <<< OMNI_SHIFT;
      w_sum[2] = ((vx_e + vy_e) * C_2000 - t_e) <<< OMNI_SHIFT;
      w_sum[3] = ((vx_e - vy_e) * C_2000 + t_e) <<< OMNI_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        s3[w] <= w_sum[w];
      end
    end
  end

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
    wik_lane u_lane (
      .clk    (clk),
      .cfg    (cfg),
      .en     (load[PIPE_DEPTH-1:PIPE_DEPTH-LANE_STAGES]),
      .sum    (s3[w]),
      .rpm    (rpm_w[w]),
      .pwm    (pwm_w[w]),
      .pulses (pulse_w[w])
    );

    assign m_tdata[w*RPM_W +: RPM_W]                  = rpm_w[w];
    assign m_tdata[PWM_BASE + w*PWM_W +: PWM_W]       = pwm_w[w];
    assign m_tdata[PULSE_BASE + w*PULSE_W +: PULSE_W] = pulse_w[w];
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline holds items after reset");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) ==
              $past($countones(vld)) + $past(in_acc) - $past(out_acc)))
    else $error("pipeline occupancy does not match accepted and delivered items");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> ((&vld) && !m_tready))
    else $error("input refused while the pipeline could move");

endmodule

// File: rtl/core/wik_regs.sv
// Configuration register file with an APB-style write and read port.
// Also registers the derived radius and pulse scale; depends on wik_pkg.
module wik_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wik_pkg::ADDR_W-1:0] paddr,
  input  logic [wik_pkg::DATA_W-1:0] pwdata,
  output logic [wik_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output wik_pkg::wik_cfg_t         cfg
);
  import wik_pkg::*;

  logic [MODE_W-1:0]    base_mode;
  logic [RPM_MW-1:0]    max_rpm;
  logic [K_W-1:0]       rpm_per_mps;
  logic [DIST_W-1:0]    lr_distance;
  logic [DIST_W-1:0]    fr_distance;
  logic [CPR_W-1:0]     counts_rev;
  logic [PER_W-1:0]     tick_ms;
  logic                 omni;
  logic [RADIUS_W-1:0]  radius;
  logic [PSCALE_W-1:0]  pulse_scale;
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode    <= RST_BASE_MODE;
      max_rpm      <= RST_MAX_RPM;
      rpm_per_mps  <= RST_RPM_PER_MPS;
      lr_distance  <= RST_LR_DISTANCE;
      fr_distance  <= RST_FR_DISTANCE;
      counts_rev   <= RST_COUNTS_REV;
      tick_ms      <= RST_TICK_MS;
    end else if (wr) begin
      case (idx)
        REG_BASE_MODE:    base_mode    <= pwdata[MODE_W-1:0];
        REG_MAX_RPM:      max_rpm      <= pwdata[RPM_MW-1:0];
        REG_RPM_PER_MPS:  rpm_per_mps  <= pwdata[K_W-1:0];
        REG_LR_DISTANCE:  lr_distance  <= pwdata[DIST_W-1:0];
        REG_FR_DISTANCE:  fr_distance  <= pwdata[DIST_W-1:0];
        REG_COUNTS_REV:   counts_rev   <= pwdata[CPR_W-1:0];
        REG_TICK_MS:      tick_ms      <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // The omni base uses twice lr_distance as its radius so that all modes share one tangential term.
  always_ff @(posedge clk) begin
    if (rst) begin
      omni        <= 1'b0;
      radius      <= RADIUS_W'(RST_LR_DISTANCE) + RADIUS_W'(RST_FR_DISTANCE);
      pulse_scale <= PSCALE_W'(RST_COUNTS_REV) * PSCALE_W'(RST_TICK_MS);
    end else begin
      omni        <= (base_mode == MODE_OMNI);
      radius      <= (base_mode == MODE_OMNI) ? {lr_distance, 1'b0} :
                     RADIUS_W'(lr_distance) + RADIUS_W'(fr_distance);
      pulse_scale <= PSCALE_W'(counts_rev) * PSCALE_W'(tick_ms);
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_MODE:    prdata = DATA_W'(base_mode);
      REG_MAX_RPM:      prdata = DATA_W'(max_rpm);
      REG_RPM_PER_MPS:  prdata = DATA_W'(rpm_per_mps);
      REG_LR_DISTANCE:  prdata = DATA_W'(lr_distance);
      REG_FR_DISTANCE:  prdata = DATA_W'(fr_distance);
      REG_COUNTS_REV:   prdata = DATA_W'(counts_rev);
      REG_TICK_MS:      prdata = DATA_W'(tick_ms);
      default:          prdata = '0;
    endcase
  end

  assign cfg.omni        = omni;
  assign cfg.max_rpm     = max_rpm;
  assign cfg.rpm_per_mps = rpm_per_mps;
  assign cfg.radius      = radius;
  assign cfg.pulse_scale = pulse_scale;

endmodule

// File: rtl/core/wik_lane.sv
// One wheel's back end: scaling by rpm per m/s, truncation, clamping, PWM and pulse conversion.
// Eight register stages enabled from the top level's valid chain; depends on wik_pkg.
module wik_lane (
  input  logic                                  clk,
  input  wik_pkg::wik_cfg_t                     cfg,
  input  logic [wik_pkg::LANE_STAGES-1:0]       en,
  input  logic signed [wik_pkg::SUM_W-1:0]      sum,
  output logic signed [wik_pkg::RPM_W-1:0]      rpm,
  output logic signed [wik_pkg::PWM_W-1:0]      pwm,
  output logic signed [wik_pkg::PULSE_W-1:0]    pulses
);
  import wik_pkg::*;

  localparam int PP_W        = PP_HALF + K_W;
  localparam int PROD_W      = MAG_W + K_W;
  localparam int QIN_W       = PROD_W - SCALE_SHIFT;
  localparam int D125_IN_W   = 19;
  localparam int D125_RW     = 20;
  localparam int D125_PW     = D125_IN_W + D125_RW;
  localparam int D125_SHIFT  = 26;
  localparam logic [D125_RW-1:0] D125_RECIP = 20'd536871;
  localparam int PPROD_W     = RPM_MW + PSCALE_W;
  localparam int PULSE_PRE   = 5;
  localparam int D1875_IN_W  = PPROD_W - PULSE_PRE;
  localparam int D1875_RW    = 28;
  localparam int D1875_PW    = D1875_IN_W + D1875_RW;
  localparam int D1875_SHIFT = 38;
  localparam logic [D1875_RW-1:0] D1875_RECIP = 28'd146601551;

  function automatic logic [RPM_MW:0] div_step(input logic [RPM_MW-1:0] rem,
                                               input logic din,
                                               input logic [RPM_MW-1:0] dvs);
    logic [RPM_MW:0] trial;
    trial = {rem, din};
    if (trial >= {1'b0, dvs}) begin
      return {1'b1, RPM_MW'(trial - {1'b0, dvs})};
    end else begin
      return {1'b0, trial[RPM_MW-1:0]};
    end
  endfunction

  logic                   sgn_a, sgn_b, sgn_c, sgn_d, sgn_e, sgn_f, sgn_g;
  logic [MAG_W-1:0]       mag_a;
  logic [PP_W-1:0]        pp_lo_b, pp_hi_b;
  logic [PROD_W-1:0]      prod_c;
  logic [QIN_W-1:0]       n_c;
  logic                   big_d;
  logic [D125_PW-1:0]     q_d;
  logic [RPM_W-1:0]       quot_e;
  logic [RPM_MW-1:0]      mag_e, mag_f, mag_g;
  logic [DIVD_W-1:0]      dividend_e, div_f;
  logic [RPM_MW-1:0]      rem1, rem_f, rem2;
  logic [PWM_QW-1:0]      quo1, quo_f, quo2, quo_g;
  logic [PPROD_W-1:0]     pprod_f;
  logic [D1875_PW-1:0]    pq_g;
  logic [PWM_W-2:0]       pwm_mag;
  logic [PULSE_W-2:0]     pulse_mag;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sgn_a <= sum[SUM_W-1];
      mag_a <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sgn_b   <= sgn_a;
      pp_lo_b <= mag_a[PP_HALF-1:0] * cfg.rpm_per_mps;
      pp_hi_b <= mag_a[MAG_W-1:PP_HALF] * cfg.rpm_per_mps;
    end
  end

  assign prod_c = {pp_hi_b, {PP_HALF{1'b0}}} + PROD_W'(pp_lo_b);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sgn_c <= sgn_b;
      n_c   <= prod_c[PROD_W-1:SCALE_SHIFT];
    end
  end

  // Division by 125 as a reciprocal multiply; anything at or above 2^19 clamps anyway.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sgn_d <= sgn_c;
      big_d <= |n_c[QIN_W-1:D125_IN_W];
      q_d   <= n_c[D125_IN_W-1:0] * D125_RECIP;
    end
  end

  assign quot_e = q_d[D125_PW-1:D125_SHIFT];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sgn_e <= sgn_d;
      mag_e <= (big_d || quot_e > {1'b0, cfg.max_rpm}) ? cfg.max_rpm : quot_e[RPM_MW-1:0];
    end
  end

  assign dividend_e = DIVD_W'(mag_e) * DIVD_W'(PWM_FULL_SCALE);

  always_comb begin
    logic [RPM_MW:0] step;
    rem1 = dividend_e[DIVD_W-1:PWM_QW];
    quo1 = '0;
    for (int i = PWM_QW - 1; i >= PWM_QW - DIV_H1; i--) begin
      step    = div_step(rem1, dividend_e[i], cfg.max_rpm);
      rem1    = step[RPM_MW-1:0];
      quo1[i] = step[RPM_MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sgn_f   <= sgn_e;
      mag_f   <= mag_e;
      div_f   <= dividend_e;
      rem_f   <= rem1;
      quo_f   <= quo1;
      pprod_f <= mag_e * cfg.pulse_scale;
    end
  end

  always_comb begin
    logic [RPM_MW:0] step;
    rem2 = rem_f;
    quo2 = quo_f;
    for (int i = PWM_QW - DIV_H1 - 1; i >= 0; i--) begin
      step    = div_step(rem2, div_f[i], cfg.max_rpm);
      rem2    = step[RPM_MW-1:0];
      quo2[i] = step[RPM_MW];
    end
  end

  // Division by 60000 is a shift by 5 and a reciprocal multiply for 1875.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      sgn_g <= sgn_f;
      mag_g <= mag_f;
      quo_g <= quo2;
      pq_g  <= pprod_f[PPROD_W-1:PULSE_PRE] * D1875_RECIP;
    end
  end

  always_comb begin
    if (mag_g == '0) begin
      pwm_mag = '0;
    end else if (32'(quo_g) > PWM_LIMIT) begin
      pwm_mag = (PWM_W - 1)'(PWM_LIMIT);
    end else begin
      pwm_mag = (PWM_W - 1)'(quo_g);
    end
  end

  assign pulse_mag = pq_g[D1875_PW-1:D1875_SHIFT];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      rpm    <= sgn_g ? -RPM_W'(mag_g) : RPM_W'(mag_g);
      pwm    <= sgn_g ? -PWM_W'(pwm_mag) : PWM_W'(pwm_mag);
      pulses <= sgn_g ? -PULSE_W'(pulse_mag) : PULSE_W'(pulse_mag);
    end
  end

endmodule
